@@ sv/scap_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scap_pkg - shared types and codes of the ATR parser
// Byte classes, error codes, parser phases and the result word layout.
// ----------------------------------------------------------------------------
package scap_pkg;

	// byte classes
	localparam logic [3:0] CLS_TS      = 4'd0;
	localparam logic [3:0] CLS_T0      = 4'd1;
	localparam logic [3:0] CLS_TA      = 4'd2;
	localparam logic [3:0] CLS_TB      = 4'd3;
	localparam logic [3:0] CLS_TC      = 4'd4;
	localparam logic [3:0] CLS_TD      = 4'd5;
	localparam logic [3:0] CLS_HIST    = 4'd6;
	localparam logic [3:0] CLS_TCK     = 4'd7;
	localparam logic [3:0] CLS_IGNORED = 4'd8;

	// error codes
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_BAD_TS     = 3'd1;
	localparam logic [2:0] ERR_MANY_GROUP = 3'd2;
	localparam logic [2:0] ERR_TOO_SHORT  = 3'd3;
	localparam logic [2:0] ERR_TOO_LONG   = 3'd4;

	// TS conventions and the proximity-card signature
	localparam logic [7:0] TS_DIRECT   = 8'h3b;
	localparam logic [7:0] TS_INVERSE  = 8'h3f;
	localparam logic [3:0] T0_PROX_HI  = 4'h8;
	localparam logic [7:0] TD1_PROX    = 8'h80;
	localparam logic [7:0] TD2_PROX    = 8'h01;

	// a TD in this group ends the interface bytes with an error
	localparam logic [2:0] MAX_GROUPS  = 3'd7;

	// parser phase, one-hot
	typedef enum logic [5:0] {
		PH_TS     = 6'b000001,
		PH_T0     = 6'b000010,
		PH_IFACE  = 6'b000100,
		PH_HIST   = 6'b001000,
		PH_AFTER  = 6'b010000,
		PH_IGNORE = 6'b100000
	} phase_t;

	// one result word
	typedef struct packed {
		logic [3:0] byte_class;
		logic [2:0] group_number;
		logic [2:0] error_code;
		logic       done_res;
		logic       tck_present;
		logic       checksum_ok;
		logic [3:0] first_protocol;
		logic       ta1_present;
		logic [7:0] ta1_value;
		logic [3:0] historical_count;
		logic       proximity_card;
	} res_t;

endpackage

@@ sv/scap_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scap_byte_if / scap_res_if - valid/ready channels of the ATR parser
// Byte channel into the parser and result channel out of it.
// ----------------------------------------------------------------------------
interface scap_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] atr_byte;
	logic       last_byte;

	modport source (output valid, output atr_byte, output last_byte, input ready);
	modport sink   (input valid, input atr_byte, input last_byte, output ready);
endinterface

interface scap_res_if;
	logic       valid;
	logic       ready;
	logic [3:0] byte_class;
	logic [2:0] group_number;
	logic [2:0] error_code;
	logic       done_res;
	logic       tck_present;
	logic       checksum_ok;
	logic [3:0] first_protocol;
	logic       ta1_present;
	logic [7:0] ta1_value;
	logic [3:0] historical_count;
	logic       proximity_card;

	modport source (
		output valid, output byte_class, output group_number, output error_code,
		output done_res, output tck_present, output checksum_ok,
		output first_protocol, output ta1_present, output ta1_value,
		output historical_count, output proximity_card, input ready
	);
	modport sink (
		input valid, input byte_class, input group_number, input error_code,
		input done_res, input tck_present, input checksum_ok,
		input first_protocol, input ta1_present, input ta1_value,
		input historical_count, input proximity_card, output ready
	);
endinterface

@@ sv/smart_card_atr_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smart_card_atr_parser - Answer To Reset byte classifier
// Classifies each ATR byte and reports a summary on the last byte.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries ATR bytes in order, starting with TS; last_byte marks the
//   final byte of one ATR. For every accepted word exactly one result word
//   leaves on res: the class of the byte and its interface group, and on the
//   last byte the error code and summary (protocol, TA1, checksum, ...).
//   After the last byte the parser is back in its reset state, ready for TS.
// Timing:
//   One word per cycle sustained while res.ready stays high. A byte is held
//   in an input stage register; the parse logic and state update sit between
//   that register and the result register, which drives res.
// Reset and stall:
//   arst_n clears both stages and the parser state (expects TS).
//   When res.ready is low the result register holds, the input stage holds
//   behind it and rx.ready drops once both are full.
// ----------------------------------------------------------------------------
module smart_card_atr_parser #(
	parameter int MAX_ATR_BYTES = 33
) (
	input  logic          clk,
	input  logic          arst_n,
	scap_byte_if.sink     rx,
	scap_res_if.source    res
);

	localparam int CW = $clog2(MAX_ATR_BYTES + 1);

	// pipeline control
	logic          valid_s1;
	logic [7:0]    atr_byte_s1;
	logic          last_s1;
	logic          out_valid_q;
	scap_pkg::res_t res_q;
	logic          advance;

	// parser state
	scap_pkg::phase_t phase_q;
	logic [3:0]    pend_q;
	logic [2:0]    group_q;
	logic [3:0]    hist_left_q;
	logic [3:0]    hist_total_q;
	logic [CW-1:0] count_q;
	logic [7:0]    xor_q;
	logic [2:0]    err_latch_q;
	logic [8:0]    td1_q;
	logic [8:0]    td2_q;
	logic [8:0]    ta1_q;
	logic [2:0]    hflags_q;

	// next state
	scap_pkg::phase_t phase_n;
	logic [3:0]    pend_n;
	logic [2:0]    group_n;
	logic [3:0]    hist_left_n;
	logic [3:0]    hist_total_n;
	logic [CW-1:0] count_n;
	logic [7:0]    xor_n;
	logic [2:0]    err_latch_n;
	logic [8:0]    td1_n;
	logic [8:0]    td2_n;
	logic [8:0]    ta1_n;
	logic [2:0]    hflags_n;
	scap_pkg::res_t res_n;
	logic [1:0]    k;
	logic          tck;

	assign advance  = !out_valid_q || res.ready;
	assign rx.ready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			atr_byte_s1 <= rx.atr_byte;
			last_s1     <= rx.last_byte;
		end
	end

	// first still-due interface byte: TA, TB, TC, else TD
	always_comb begin
		if (pend_q[0]) k = 2'd0;
		else if (pend_q[1]) k = 2'd1;
		else if (pend_q[2]) k = 2'd2;
		else k = 2'd3;
	end

	// parse one byte
	always_comb begin
		phase_n      = phase_q;
		pend_n       = pend_q;
		group_n      = group_q;
		hist_left_n  = hist_left_q;
		hist_total_n = hist_total_q;
		err_latch_n  = err_latch_q;
		td1_n        = td1_q;
		td2_n        = td2_q;
		ta1_n        = ta1_q;
		hflags_n     = hflags_q;
		tck          = 1'b0;
		res_n        = '0;
		res_n.byte_class = scap_pkg::CLS_IGNORED;

		// saturating byte count
		if (count_q >= CW'(MAX_ATR_BYTES)) begin
			count_n     = count_q;
			hflags_n[2] = 1'b1;
		end else begin
			count_n = count_q + CW'(1);
		end

		xor_n = (phase_q != scap_pkg::PH_TS) ? (xor_q ^ atr_byte_s1) : xor_q;

		unique case (phase_q)
			scap_pkg::PH_TS: begin
				res_n.byte_class = scap_pkg::CLS_TS;
				if (atr_byte_s1 == scap_pkg::TS_DIRECT) begin
					hflags_n[0] = 1'b1;
					phase_n     = scap_pkg::PH_T0;
				end else if (atr_byte_s1 == scap_pkg::TS_INVERSE) begin
					phase_n = scap_pkg::PH_T0;
				end else begin
					err_latch_n = scap_pkg::ERR_BAD_TS;
					phase_n     = scap_pkg::PH_IGNORE;
				end
			end
			scap_pkg::PH_T0: begin
				res_n.byte_class = scap_pkg::CLS_T0;
				hist_total_n = atr_byte_s1[3:0];
				hist_left_n  = atr_byte_s1[3:0];
				if (atr_byte_s1[7:4] == scap_pkg::T0_PROX_HI) hflags_n[1] = 1'b1;
				pend_n  = atr_byte_s1[7:4];
				group_n = 3'd1;
				if (atr_byte_s1[7:4] != 4'd0) phase_n = scap_pkg::PH_IFACE;
				else if (atr_byte_s1[3:0] != 4'd0) phase_n = scap_pkg::PH_HIST;
				else phase_n = scap_pkg::PH_AFTER;
			end
			scap_pkg::PH_IFACE: begin
				if (pend_q != 4'd0) begin
					res_n.byte_class   = scap_pkg::CLS_TA + {2'd0, k};
					res_n.group_number = group_q;
					pend_n[k]          = 1'b0;
					if (k == 2'd0 && group_q == 3'd1) ta1_n = {1'b1, atr_byte_s1};
					if (k == 2'd3) begin
						if (group_q == 3'd1) td1_n = {1'b1, atr_byte_s1};
						if (group_q == 3'd2) td2_n = {1'b1, atr_byte_s1};
						if (group_q >= scap_pkg::MAX_GROUPS) begin
							err_latch_n = scap_pkg::ERR_MANY_GROUP;
						end else begin
							group_n = group_q + 3'd1;
							pend_n  = atr_byte_s1[7:4];
						end
					end
				end
				// leave the interface phase once nothing is due, or on a TD at the group limit
				if (k == 2'd3 && pend_q != 4'd0 && group_q >= scap_pkg::MAX_GROUPS)
					phase_n = scap_pkg::PH_IGNORE;
				else if (pend_n != 4'd0) phase_n = scap_pkg::PH_IFACE;
				else if (hist_left_q != 4'd0) phase_n = scap_pkg::PH_HIST;
				else phase_n = scap_pkg::PH_AFTER;
			end
			scap_pkg::PH_HIST: begin
				res_n.byte_class = scap_pkg::CLS_HIST;
				if (hist_left_q != 4'd0) hist_left_n = hist_left_q - 4'd1;
				if (hist_left_n == 4'd0) phase_n = scap_pkg::PH_AFTER;
			end
			scap_pkg::PH_AFTER: begin
				if (last_s1) begin
					res_n.byte_class = scap_pkg::CLS_TCK;
					tck = 1'b1;
				end
				phase_n = scap_pkg::PH_IGNORE;
			end
			default: begin
				phase_n = scap_pkg::PH_IGNORE;
			end
		endcase

		// summary on the last byte
		if (last_s1) begin
			if (hflags_n[2]) res_n.error_code = scap_pkg::ERR_TOO_LONG;
			else if (count_n < CW'(2)) res_n.error_code = scap_pkg::ERR_TOO_SHORT;
			else if (err_latch_n != scap_pkg::ERR_NONE) res_n.error_code = err_latch_n;
			else if (phase_n != scap_pkg::PH_AFTER && phase_n != scap_pkg::PH_IGNORE)
				res_n.error_code = scap_pkg::ERR_TOO_SHORT;
			else res_n.error_code = scap_pkg::ERR_NONE;
			res_n.done_res         = 1'b1;
			res_n.tck_present      = tck;
			res_n.checksum_ok      = tck && (xor_n == 8'd0);
			res_n.first_protocol   = td1_n[8] ? td1_n[3:0] : 4'd0;
			res_n.ta1_present      = ta1_n[8];
			res_n.ta1_value        = ta1_n[7:0];
			res_n.historical_count = hist_total_n;
			res_n.proximity_card   = (hflags_n[1:0] == 2'b11)
				&& (td1_n == {1'b1, scap_pkg::TD1_PROX})
				&& (td2_n == {1'b1, scap_pkg::TD2_PROX});
		end
	end

	// parser state, cleared after each last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= scap_pkg::PH_TS;
			pend_q       <= '0;
			group_q      <= '0;
			hist_left_q  <= '0;
			hist_total_q <= '0;
			count_q      <= '0;
			xor_q        <= '0;
			err_latch_q  <= '0;
			td1_q        <= '0;
			td2_q        <= '0;
			ta1_q        <= '0;
			hflags_q     <= '0;
		end else if (valid_s1 && advance) begin
			if (last_s1) begin
				phase_q      <= scap_pkg::PH_TS;
				pend_q       <= '0;
				group_q      <= '0;
				hist_left_q  <= '0;
				hist_total_q <= '0;
				count_q      <= '0;
				xor_q        <= '0;
				err_latch_q  <= '0;
				td1_q        <= '0;
				td2_q        <= '0;
				ta1_q        <= '0;
				hflags_q     <= '0;
			end else begin
				phase_q      <= phase_n;
				pend_q       <= pend_n;
				group_q      <= group_n;
				hist_left_q  <= hist_left_n;
				hist_total_q <= hist_total_n;
				count_q      <= count_n;
				xor_q        <= xor_n;
				err_latch_q  <= err_latch_n;
				td1_q        <= td1_n;
				td2_q        <= td2_n;
				ta1_q        <= ta1_n;
				hflags_q     <= hflags_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) res_q <= res_n;
	end

	assign res.valid            = out_valid_q;
	assign res.byte_class       = res_q.byte_class;
	assign res.group_number     = res_q.group_number;
	assign res.error_code       = res_q.error_code;
	assign res.done_res         = res_q.done_res;
	assign res.tck_present      = res_q.tck_present;
	assign res.checksum_ok      = res_q.checksum_ok;
	assign res.first_protocol   = res_q.first_protocol;
	assign res.ta1_present      = res_q.ta1_present;
	assign res.ta1_value        = res_q.ta1_value;
	assign res.historical_count = res_q.historical_count;
	assign res.proximity_card   = res_q.proximity_card;

endmodule

@@ sv/scap_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scap_checker - port-level checks of the ATR parser
// Watches the result channel; bound to the parser module.
// ----------------------------------------------------------------------------
module scap_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [3:0] byte_class,
	input logic [2:0] group_number,
	input logic [2:0] error_code,
	input logic       done_res,
	input logic       tck_present,
	input logic       checksum_ok
);

	// a stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(byte_class)
		&& $stable(group_number) && $stable(error_code) && $stable(done_res))
		else $error("result word changed under stall");

	// error code, TCK and checksum flags stay zero on words that are not the last
	a_no_summary: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !done_res |-> error_code == scap_pkg::ERR_NONE
		&& !tck_present && !checksum_ok)
		else $error("summary on a non-final word");

	// TCK only on the last word, classified as TCK
	a_tck_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && tck_present |-> done_res && byte_class == scap_pkg::CLS_TCK)
		else $error("TCK flag without final TCK word");

	// a group number only on interface bytes
	a_group: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && group_number != 3'd0 |-> byte_class == scap_pkg::CLS_TA
		|| byte_class == scap_pkg::CLS_TB || byte_class == scap_pkg::CLS_TC
		|| byte_class == scap_pkg::CLS_TD)
		else $error("group number on a non-interface byte");

	// checksum status needs a TCK
	a_chk: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && checksum_ok |-> tck_present)
		else $error("checksum ok without TCK");

endmodule

bind smart_card_atr_parser scap_checker u_scap_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.byte_class   (res.byte_class),
	.group_number (res.group_number),
	.error_code   (res.error_code),
	.done_res     (res.done_res),
	.tck_present  (res.tck_present),
	.checksum_ok  (res.checksum_ok)
);

@@ dv/tb_smart_card_atr_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smart_card_atr_parser - self-checking bench for the ATR parser
// A short table of hand-built ATRs runs first, then random ATRs: mostly
// well-formed ones with random content, plus noise, truncated and overlong
// ones. Every accepted byte goes through a parser model kept here; each result
// word is checked field by field, in order, against it or, for typed rows, the table.
// ----------------------------------------------------------------------------
module tb_smart_card_atr_parser;

	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 7;
	localparam int ATR_MAX_BYTES = 33;
	localparam int ITEM_TARGET   = 1900;
	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 300;
	localparam int HOLD_AFTER    = 400;
	localparam int DRAIN_CYCLES  = 8;

	// one stimulus word; cls/err/done only count when typed is set
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       typed;
		logic [3:0] cls;
		logic [2:0] err;
		logic       done;
	} atr_word_t;

	localparam int DIR_ROWS = 24;
	localparam atr_word_t DIR_TABLE [DIR_ROWS] = '{
		// lone TS marked last
		'{8'h3b, 1'b1, 1'b1, scap_pkg::CLS_TS,      scap_pkg::ERR_TOO_SHORT,  1'b1},
		// bad TS, then the rest is ignored
		'{8'h00, 1'b0, 1'b1, scap_pkg::CLS_TS,      scap_pkg::ERR_NONE,       1'b0},
		'{8'hff, 1'b1, 1'b1, scap_pkg::CLS_IGNORED, scap_pkg::ERR_BAD_TS,     1'b1},
		// bare T0, two trailing bytes: no TCK, both ignored
		'{8'h3b, 1'b0, 1'b1, scap_pkg::CLS_TS,      scap_pkg::ERR_NONE,       1'b0},
		'{8'h00, 1'b0, 1'b1, scap_pkg::CLS_T0,      scap_pkg::ERR_NONE,       1'b0},
		'{8'h55, 1'b0, 1'b1, scap_pkg::CLS_IGNORED, scap_pkg::ERR_NONE,       1'b0},
		'{8'haa, 1'b1, 1'b1, scap_pkg::CLS_IGNORED, scap_pkg::ERR_NONE,       1'b1},
		// proximity-card signature with a good TCK
		'{8'h3b, 1'b0, 1'b0, scap_pkg::CLS_IGNORED, scap_pkg::ERR_NONE,       1'b0},
		'{8'h80, 1'b0, 1'b0, scap_pkg::CLS_IGNORED, scap_pkg::ERR_NONE,       1'b0},
		'{8'h80, 1'b0, 1'b0, scap_pkg::CLS_IGNORED, scap_pkg::ERR_NONE,       1'b0},
		'{8'h01, 1'b0, 1'b0, scap_pkg::CLS_IGNORED, scap_pkg::ERR_NONE,       1'b0},
		'{8'h01, 1'b1, 1'b0, scap_pkg::CLS_IGNORED, scap_pkg::ERR_NONE,       1'b0},
		// TD chain running into the group limit
		'{8'h3f, 1'b0, 1'b0, scap_pkg::CLS_IGNORED, scap_pkg::ERR_NONE,       1'b0},
		'{8'h80, 1'b0, 1'b0, scap_pkg::CLS_IGNORED, scap_pkg::ERR_NONE,       1'b0},
		'{8'h80, 1'b0, 1'b0, scap_pkg::CLS_IGNORED, scap_pkg::ERR_NONE,       1'b0},
		'{8'h80, 1'b0, 1'b0, scap_pkg::CLS_IGNORED, scap_pkg::ERR_NONE,       1'b0},
		'{8'h80, 1'b0, 1'b0, scap_pkg::CLS_IGNORED, scap_pkg::ERR_NONE,       1'b0},
		'{8'h80, 1'b0, 1'b0, scap_pkg::CLS_IGNORED, scap_pkg::ERR_NONE,       1'b0},
		'{8'h80, 1'b0, 1'b0, scap_pkg::CLS_IGNORED, scap_pkg::ERR_NONE,       1'b0},
		'{8'h80, 1'b0, 1'b0, scap_pkg::CLS_IGNORED, scap_pkg::ERR_NONE,       1'b0},
		'{8'h80, 1'b0, 1'b0, scap_pkg::CLS_IGNORED, scap_pkg::ERR_NONE,       1'b0},
		'{8'h00, 1'b1, 1'b1, scap_pkg::CLS_IGNORED, scap_pkg::ERR_MANY_GROUP, 1'b1},
		// cut off right after T0 with all interface bytes due
		'{8'h3b, 1'b0, 1'b0, scap_pkg::CLS_IGNORED, scap_pkg::ERR_NONE,       1'b0},
		'{8'hf0, 1'b1, 1'b0, scap_pkg::CLS_IGNORED, scap_pkg::ERR_NONE,       1'b0}
	};

	logic clk;
	logic arst_n;

	scap_byte_if rx_if();
	scap_res_if  res_if();

	smart_card_atr_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if)
	);

	// parser model state
	scap_pkg::phase_t ph_now;
	logic [3:0] due_mask;
	logic [3:0] grp_idx;
	logic [3:0] hist_left;
	logic [3:0] hist_total;
	logic [5:0] seen_cnt;
	logic [7:0] run_xor;
	logic [2:0] err_hold;
	logic       td1_seen, td2_seen, ta1_seen;
	logic [7:0] td1_val, td2_val, ta1_val;
	logic       direct_conv, t0_prox, over_len;

	atr_word_t      atr_words[$];
	scap_pkg::res_t expected_q[$];
	int        mismatches;
	int        words_in;
	int        words_out;
	int        idle_cycles;
	int        item_count;

	// clock and reset
	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic void clear_parser_model();
		ph_now      = scap_pkg::PH_TS;
		due_mask    = '0;
		grp_idx     = '0;
		hist_left   = '0;
		hist_total  = '0;
		seen_cnt    = '0;
		run_xor     = '0;
		err_hold    = scap_pkg::ERR_NONE;
		td1_seen    = 1'b0;
		td2_seen    = 1'b0;
		ta1_seen    = 1'b0;
		td1_val     = '0;
		td2_val     = '0;
		ta1_val     = '0;
		direct_conv = 1'b0;
		t0_prox     = 1'b0;
		over_len    = 1'b0;
	endfunction

	// where the parser goes once the current interface group is used up
	function automatic scap_pkg::phase_t phase_after_group();
		if (due_mask != 4'd0)
			return scap_pkg::PH_IFACE;
		return (hist_left != 4'd0) ? scap_pkg::PH_HIST : scap_pkg::PH_AFTER;
	endfunction

	// classify one ATR byte and advance the model; summary on the last byte
	function automatic scap_pkg::res_t classify_atr_byte(input logic [7:0] b,
		input logic last);
		scap_pkg::res_t r;
		int   k;
		logic tck;
		r = '0;
		r.byte_class = scap_pkg::CLS_IGNORED;
		tck = 1'b0;

		if (seen_cnt >= ATR_MAX_BYTES)
			over_len = 1'b1;
		else
			seen_cnt++;
		if (ph_now != scap_pkg::PH_TS)
			run_xor ^= b;

		case (ph_now)
			scap_pkg::PH_TS: begin
				r.byte_class = scap_pkg::CLS_TS;
				if (b == scap_pkg::TS_DIRECT) begin
					direct_conv = 1'b1;
					ph_now = scap_pkg::PH_T0;
				end else if (b == scap_pkg::TS_INVERSE) begin
					ph_now = scap_pkg::PH_T0;
				end else begin
					err_hold = scap_pkg::ERR_BAD_TS;
					ph_now = scap_pkg::PH_IGNORE;
				end
			end
			scap_pkg::PH_T0: begin
				r.byte_class = scap_pkg::CLS_T0;
				hist_total = b[3:0];
				hist_left = b[3:0];
				if (b[7:4] == scap_pkg::T0_PROX_HI)
					t0_prox = 1'b1;
				due_mask = b[7:4];
				grp_idx = 4'd1;
				ph_now = phase_after_group();
			end
			scap_pkg::PH_IFACE: begin
				if (due_mask == 4'd0) begin
					ph_now = phase_after_group();
				end else begin
					k = 0;
					while (k < 3 && !due_mask[k])
						k++;
					r.byte_class = scap_pkg::CLS_TA + 4'(k);
					r.group_number = grp_idx[2:0];
					due_mask[k] = 1'b0;
					if (k == 0 && grp_idx == 4'd1) begin
						ta1_seen = 1'b1;
						ta1_val = b;
					end
					if (k == 3) begin
						if (grp_idx == 4'd1) begin
							td1_seen = 1'b1;
							td1_val = b;
						end
						if (grp_idx == 4'd2) begin
							td2_seen = 1'b1;
							td2_val = b;
						end
						if (grp_idx >= scap_pkg::MAX_GROUPS) begin
							err_hold = scap_pkg::ERR_MANY_GROUP;
							ph_now = scap_pkg::PH_IGNORE;
						end else begin
							grp_idx++;
							due_mask = b[7:4];
							ph_now = phase_after_group();
						end
					end else begin
						ph_now = phase_after_group();
					end
				end
			end
			scap_pkg::PH_HIST: begin
				r.byte_class = scap_pkg::CLS_HIST;
				if (hist_left != 4'd0)
					hist_left--;
				if (hist_left == 4'd0)
					ph_now = scap_pkg::PH_AFTER;
			end
			scap_pkg::PH_AFTER: begin
				// the byte after the historical bytes is TCK only when it is the last byte
				if (last) begin
					r.byte_class = scap_pkg::CLS_TCK;
					tck = 1'b1;
				end
				ph_now = scap_pkg::PH_IGNORE;
			end
			default: ph_now = scap_pkg::PH_IGNORE;
		endcase

		if (!last)
			return r;

		// error precedence: too long, too short, latched, bytes still due
		if (over_len)
			r.error_code = scap_pkg::ERR_TOO_LONG;
		else if (seen_cnt < 6'd2)
			r.error_code = scap_pkg::ERR_TOO_SHORT;
		else if (err_hold != scap_pkg::ERR_NONE)
			r.error_code = err_hold;
		else if (ph_now == scap_pkg::PH_TS || ph_now == scap_pkg::PH_T0 ||
		         ph_now == scap_pkg::PH_IFACE || ph_now == scap_pkg::PH_HIST)
			r.error_code = scap_pkg::ERR_TOO_SHORT;

		r.done_res         = 1'b1;
		r.tck_present      = tck;
		r.checksum_ok      = tck && (run_xor == 8'd0);
		r.first_protocol   = td1_seen ? td1_val[3:0] : 4'd0;
		r.ta1_present      = ta1_seen;
		r.ta1_value        = ta1_val;
		r.historical_count = hist_total;
		r.proximity_card   = direct_conv && t0_prox && td1_seen &&
		                     td1_val == scap_pkg::TD1_PROX &&
		                     td2_seen && td2_val == scap_pkg::TD2_PROX;
		clear_parser_model();
		return r;
	endfunction

	// append one random ATR to the stimulus
	task automatic queue_random_atr();
		logic [7:0] seq[$];
		logic [7:0] t0, b, sum;
		logic [3:0] due;
		atr_word_t  w;
		int         style, tail, grp, n, k, i;
		style = $urandom_range(0, 19);
		if (style < 2) begin
			// plain noise
			n = $urandom_range(1, 6);
			repeat (n) seq.push_back(8'($urandom));
		end else begin
			if (style == 2)
				seq.push_back(8'($urandom));
			else
				seq.push_back($urandom_range(0, 1) ? scap_pkg::TS_DIRECT :
					scap_pkg::TS_INVERSE);
			t0 = 8'($urandom);
			if ($urandom_range(0, 3) != 0)
				t0[3:0] = 4'($urandom_range(0, 5));
			if (style == 3)
				t0[7:4] = scap_pkg::T0_PROX_HI;
			seq.push_back(t0);
			sum = t0;
			due = t0[7:4];
			grp = 1;
			// interface groups; style 4 keeps chaining up to the group limit
			while (due != 4'd0 && grp <= scap_pkg::MAX_GROUPS) begin
				for (k = 0; k < 3; k++)
					if (due[k]) begin
						b = 8'($urandom);
						seq.push_back(b);
						sum ^= b;
					end
				if (due[3]) begin
					b = 8'($urandom);
					if (style == 3)
						b = (grp == 1) ? scap_pkg::TD1_PROX : scap_pkg::TD2_PROX;
					else if (style == 4)
						b[7] = 1'b1;
					else if ($urandom_range(0, 2) != 0)
						b[7] = 1'b0;
					seq.push_back(b);
					sum ^= b;
					due = b[7:4];
				end else begin
					due = 4'd0;
				end
				grp++;
			end
			repeat (t0[3:0]) begin
				b = 8'($urandom);
				seq.push_back(b);
				sum ^= b;
			end
			tail = $urandom_range(0, 9);
			case (tail)
				5: seq.push_back(sum ^ 8'($urandom_range(1, 255)));
				6: ;
				7: repeat ($urandom_range(2, 4)) seq.push_back(8'($urandom));
				8: begin
					// long tail, may run past the length limit
					repeat ($urandom_range(1, 40)) seq.push_back(8'($urandom));
				end
				9: begin
					n = $urandom_range(1, seq.size());
					while (seq.size() > n)
						void'(seq.pop_back());
				end
				default: seq.push_back(sum);
			endcase
		end
		item_count += seq.size();
		for (i = 0; i < seq.size(); i++) begin
			w = '0;
			w.data = seq[i];
			w.last = (i == seq.size() - 1);
			atr_words.push_back(w);
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: result %0d: %s got %0d, expected %0d", $realtime, words_out,
			what, got, want);
		mismatches++;
	endtask

	// handshake bookkeeping for the stall watchdog and the hold-off
	always @(posedge clk) begin
		if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (rx_if.valid && rx_if.ready)
			words_in <= words_in + 1;
	end

	initial begin
		idle_cycles = 0;
		wait (idle_cycles >= STALL_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// byte sender: bursts with random gaps, then drain and verdict
	initial begin : byte_sender
		atr_word_t      w;
		scap_pkg::res_t want;
		int        burst, gap, i;
		rx_if.valid = 1'b0;
		rx_if.atr_byte = '0;
		rx_if.last_byte = 1'b0;
		mismatches = 0;
		words_in = 0;
		item_count = DIR_ROWS;
		clear_parser_model();
		for (i = 0; i < DIR_ROWS; i++)
			atr_words.push_back(DIR_TABLE[i]);
		while (item_count < ITEM_TARGET)
			queue_random_atr();

		wait (arst_n);
		@(posedge clk);
		while (atr_words.size() != 0) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && atr_words.size() != 0) begin
				w = atr_words.pop_front();
				rx_if.valid <= 1'b1;
				rx_if.atr_byte <= w.data;
				rx_if.last_byte <= w.last;
				@(posedge clk);
				while (!rx_if.ready)
					@(posedge clk);
				want = classify_atr_byte(w.data, w.last);
				if (w.typed) begin
					want = '0;
					want.byte_class = w.cls;
					want.error_code = w.err;
					want.done_res = w.done;
				end
				expected_q.push_back(want);
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				rx_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		rx_if.valid <= 1'b0;

		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// result receiver: its own stall modes, plus one long hold-off
	initial begin : result_receiver
		int   mode, span;
		logic held;
		res_if.ready = 1'b0;
		held = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			repeat (span) begin
				if (!held && words_in >= HOLD_AFTER) begin
					held = 1'b1;
					res_if.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end
				case (mode)
					0: res_if.ready <= 1'b1;
					1: res_if.ready <= ($urandom_range(0, 3) != 0);
					2: res_if.ready <= ($urandom_range(0, 3) == 0);
					default: res_if.ready <= ~res_if.ready;
				endcase
				@(posedge clk);
			end
		end
	end

	// compare each result word with the oldest expectation
	always @(posedge clk) begin : result_check
		scap_pkg::res_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected word, class", res_if.byte_class, -1);
			end else begin
				want = expected_q.pop_front();
				if (res_if.byte_class !== want.byte_class)
					report_mismatch("byte_class", res_if.byte_class, want.byte_class);
				if (res_if.group_number !== want.group_number)
					report_mismatch("group_number", res_if.group_number, want.group_number);
				if (res_if.error_code !== want.error_code)
					report_mismatch("error_code", res_if.error_code, want.error_code);
				if (res_if.done_res !== want.done_res)
					report_mismatch("done_res", res_if.done_res, want.done_res);
				if (res_if.tck_present !== want.tck_present)
					report_mismatch("tck_present", res_if.tck_present, want.tck_present);
				if (res_if.checksum_ok !== want.checksum_ok)
					report_mismatch("checksum_ok", res_if.checksum_ok, want.checksum_ok);
				if (res_if.first_protocol !== want.first_protocol)
					report_mismatch("first_protocol", res_if.first_protocol,
						want.first_protocol);
				if (res_if.ta1_present !== want.ta1_present)
					report_mismatch("ta1_present", res_if.ta1_present, want.ta1_present);
				if (res_if.ta1_value !== want.ta1_value)
					report_mismatch("ta1_value", res_if.ta1_value, want.ta1_value);
				if (res_if.historical_count !== want.historical_count)
					report_mismatch("historical_count", res_if.historical_count,
						want.historical_count);
				if (res_if.proximity_card !== want.proximity_card)
					report_mismatch("proximity_card", res_if.proximity_card,
						want.proximity_card);
			end
			words_out++;
		end
	end

	initial words_out = 0;

endmodule

@@ smart_card_atr_parser.f @@
sv/scap_pkg.sv
sv/scap_if.sv
sv/smart_card_atr_parser.sv
sv/scap_checker.sv
dv/tb_smart_card_atr_parser.sv
